@@ rtl/cmdv_pkg.sv @@
// ----------------------------------------------------------------------------
// cmdv_pkg
// Shared constants, codes and helpers of the command line validator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdv_pkg;

  // default raw line limit and register reset
  localparam int unsigned LineMaxDefault = 256;
  localparam logic [7:0]  MaxLenReset    = 8'd200;

  // error codes, in priority order
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_EMPTY      = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd3;
  localparam logic [2:0] ERR_BAD_FORMAT = 3'd4;
  localparam logic [2:0] ERR_NO_ACTION  = 3'd5;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd6;
  localparam logic [2:0] ERR_BAD_ACTION = 3'd7;

  // command kinds
  localparam logic [1:0] KIND_GET  = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // prefix match states: 0..4 count matched bytes of "CMND "
  localparam logic [2:0] PFX_PRE_SPACE = 3'd4;
  localparam logic [2:0] PFX_DONE      = 3'd5;
  localparam logic [2:0] PFX_FAIL      = 3'd7;

  // type match states
  localparam logic [2:0] TYP_IDLE = 3'd0;
  localparam logic [2:0] TYP_G    = 3'd1;
  localparam logic [2:0] TYP_S    = 3'd2;
  localparam logic [2:0] TYP_GE   = 3'd3;
  localparam logic [2:0] TYP_SE   = 3'd4;
  localparam logic [2:0] TYP_GET  = 3'd5;
  localparam logic [2:0] TYP_SET  = 3'd6;
  localparam logic [2:0] TYP_FAIL = 3'd7;

  // character codes
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_TILDE   = 8'd126;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;

  // summary of one finished line, handed to the result stage
  typedef struct packed {
    logic       started;
    logic       raw_over;
    logic [7:0] trim_hi;     // trimmed count, upper bits folded into a flag below
    logic       trim_big;    // trimmed count above 255
    logic       bad_char;
    logic [2:0] prefix;
    logic [1:0] fields;
    logic [2:0] typ;
    logic [7:0] act_start;
    logic [7:0] act_cnt;
    logic       act_bad;
    logic [7:0] pay_start;
    logic [7:0] pay_cnt;
  } line_sum_t;

  // whitespace: tab through carriage return, and space
  function automatic logic is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  // printable range check
  function automatic logic is_ctrl(input logic [7:0] c);
    return (c < CH_SPACE) || (c > CH_TILDE);
  endfunction

  // letters, digits, '.', '_' and '-'
  function automatic logic is_action_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "0") && (c <= "9")) || (c == ".") || (c == "_") || (c == "-");
  endfunction

  // expected byte of the "CMND " prefix at match state p
  function automatic logic [7:0] prefix_char(input logic [2:0] p);
    logic [7:0] ch;
    unique case (p)
      3'd0:    ch = "C";
      3'd1:    ch = "M";
      3'd2:    ch = "N";
      3'd3:    ch = "D";
      default: ch = CH_SPACE;
    endcase
    return ch;
  endfunction

  // GET / SET recognizer
  function automatic logic [2:0] type_next(input logic [2:0] s, input logic [7:0] c);
    logic [2:0] n;
    n = TYP_FAIL;
    if ((s == TYP_IDLE) && (c == "G")) n = TYP_G;
    if ((s == TYP_IDLE) && (c == "S")) n = TYP_S;
    if ((s == TYP_G) && (c == "E"))    n = TYP_GE;
    if ((s == TYP_S) && (c == "E"))    n = TYP_SE;
    if ((s == TYP_GE) && (c == "T"))   n = TYP_GET;
    if ((s == TYP_SE) && (c == "T"))   n = TYP_SET;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/command_line_validator.sv @@
// ----------------------------------------------------------------------------
// command_line_validator
// Byte-wise checker for one line of the "CMND <type> <action> [payload]"
// text protocol, reporting validity, first error and field positions.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one raw byte per word in tdata[7:0], tlast on the final byte of
//   the line. Bytes are taken at one per cycle when not stalled; the parse
//   state is updated by a single pass of logic behind an input register.
//   m_axis: one result word per line, produced only for the tlast byte.
//   Result path: the last byte passes the input register, the line
//   summary register and the result register, in that order.
//   cfg: write of max_trimmed_length, taken in any cycle, meant for use
//   while no line is in flight.
//   Throughput: one byte per cycle when not stalled; set by the per-byte
//   state update loop, which is a single pass of combinational logic.
//   Stalls: while the result register is held by m_axis_tready low, bytes
//   of the next line keep flowing; only a second finished line waits, and
//   then s_axis_tready drops once the summary register is also full.
//   Reset: clears all line state and sets max_trimmed_length to 200.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_validator #(
  parameter int unsigned LINE_MAX = cmdv_pkg::LineMaxDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  wire logic        s_axis_tlast,   // last_char
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [2:0] error_code, [10:3] action_offset,
                                           // [18:11] action_length,
                                           // [26:19] payload_offset,
                                           // [34:27] payload_length, [39:35] zero
  output logic [2:0]       m_axis_tuser,   // [0] line_valid, [2:1] command_kind
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i      // max_trimmed_length
);

  localparam int unsigned CW = $clog2(LINE_MAX + 2);
  localparam int unsigned PW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam logic [CW-1:0] CapV = CW'(LINE_MAX + 1);

  // saturate a wide position to 8 bits
  function automatic logic [7:0] sat8(input logic [PW-1:0] x);
    return (x > PW'(255)) ? 8'hFF : x[7:0];
  endfunction

  // increment with a cap at LINE_MAX+1
  function automatic logic [CW-1:0] inc_cap(input logic [CW-1:0] x);
    return (x >= CapV) ? CapV : x + CW'(1);
  endfunction

  // configuration register
  logic [7:0] max_len_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= cmdv_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  // pipeline handshake
  logic s1_v_q, s1_last_q;
  logic [7:0] s1_char_q;
  logic s2_v_q;
  cmdv_pkg::line_sum_t s2_q, sum_d;
  logic m_valid_q;
  logic out_free, s2_free, s1_adv;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s2_free       = !s2_v_q || out_free;
  assign s1_adv        = s1_v_q && (!s1_last_q || s2_free);
  assign s_axis_tready = !s1_v_q || s1_adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_char_q <= s_axis_tdata;
      s1_last_q <= s_axis_tlast;
    end
  end

  // line state
  logic [CW-1:0] byte_idx_q, byte_idx_d;
  logic          started_q, started_d;
  logic [CW-1:0] trim_cnt_q, trim_cnt_d;
  logic [CW-1:0] pend_ws_q, pend_ws_d;
  logic          pend_ctl_q, pend_ctl_d;
  logic          bad_char_q, bad_char_d;
  logic [1:0]    fields_q, fields_d;
  logic [2:0]    prefix_q, prefix_d;
  logic [2:0]    typ_q, typ_d;
  logic [7:0]    act_start_q, act_start_d;
  logic [7:0]    act_cnt_q, act_cnt_d;
  logic          act_bad_q, act_bad_d;
  logic [7:0]    pay_start_q, pay_start_d;
  logic [7:0]    pay_cnt_q, pay_cnt_d;

  // scratch of the update pass
  logic [CW-1:0] ws_left;
  logic [PW-1:0] ws_pos;
  logic [PW-1:0] trim_sum;
  logic [CW-1:0] base;

  // per-byte update: fold the pending space run, then the byte itself
  always_comb begin
    byte_idx_d  = inc_cap(byte_idx_q);
    started_d   = started_q;
    trim_cnt_d  = trim_cnt_q;
    pend_ws_d   = pend_ws_q;
    pend_ctl_d  = pend_ctl_q;
    bad_char_d  = bad_char_q;
    fields_d    = fields_q;
    prefix_d    = prefix_q;
    typ_d       = typ_q;
    act_start_d = act_start_q;
    act_cnt_d   = act_cnt_q;
    act_bad_d   = act_bad_q;
    pay_start_d = pay_start_q;
    pay_cnt_d   = pay_cnt_q;
    ws_left     = pend_ws_q;
    base        = (byte_idx_q >= pend_ws_q) ? byte_idx_q - pend_ws_q : '0;
    ws_pos      = PW'(base);
    trim_sum    = PW'(trim_cnt_q) + PW'(pend_ws_q) + PW'(1);

    if (cmdv_pkg::is_ws(s1_char_q)) begin
      // whitespace is held until later content shows it is inside the line
      if (started_q) begin
        pend_ws_d = inc_cap(pend_ws_q);
        if (s1_char_q != cmdv_pkg::CH_SPACE) begin
          pend_ctl_d = 1'b1;
        end
      end
    end else begin
      started_d  = 1'b1;
      trim_cnt_d = (trim_sum > PW'(CapV)) ? CapV : trim_sum[CW-1:0];
      pend_ws_d  = '0;
      pend_ctl_d = 1'b0;

      if (pend_ctl_q) begin
        bad_char_d = 1'b1;
      end else if (ws_left != '0) begin
        // space run through the prefix matcher
        if (prefix_q < cmdv_pkg::PFX_PRE_SPACE) begin
          prefix_d = cmdv_pkg::PFX_FAIL;
          ws_left  = '0;
        end else if (prefix_q == cmdv_pkg::PFX_PRE_SPACE) begin
          prefix_d = cmdv_pkg::PFX_DONE;
          ws_left  = ws_left - CW'(1);
          ws_pos   = ws_pos + PW'(1);
        end
        // space run through the field splitter
        if (prefix_d == cmdv_pkg::PFX_DONE) begin
          if ((fields_d == 2'd0) && (ws_left != '0)) begin
            fields_d    = 2'd1;
            act_start_d = sat8(ws_pos + PW'(1));
            ws_left     = ws_left - CW'(1);
            ws_pos      = ws_pos + PW'(1);
          end
          if ((fields_d == 2'd1) && (ws_left != '0)) begin
            fields_d    = 2'd2;
            pay_start_d = sat8(ws_pos + PW'(1));
            ws_left     = ws_left - CW'(1);
          end
          if (fields_d == 2'd2) begin
            pay_cnt_d = sat8(PW'(pay_cnt_q) + PW'(ws_left));
          end
        end
      end

      if (cmdv_pkg::is_ctrl(s1_char_q)) begin
        bad_char_d = 1'b1;
      end

      // the content byte itself
      if (prefix_d < cmdv_pkg::PFX_DONE) begin
        prefix_d = (s1_char_q == cmdv_pkg::prefix_char(prefix_d)) ?
                   prefix_d + 3'd1 : cmdv_pkg::PFX_FAIL;
      end else if (prefix_d == cmdv_pkg::PFX_DONE) begin
        case (fields_d)
          2'd0: typ_d = cmdv_pkg::type_next(typ_q, s1_char_q);
          2'd1: begin
            act_cnt_d = (act_cnt_q == 8'hFF) ? 8'hFF : act_cnt_q + 8'd1;
            if (!cmdv_pkg::is_action_char(s1_char_q)) begin
              act_bad_d = 1'b1;
            end
          end
          default: pay_cnt_d = (pay_cnt_d == 8'hFF) ? 8'hFF : pay_cnt_d + 8'd1;
        endcase
      end
    end
  end

  // line summary from the updated state
  always_comb begin
    sum_d.started   = started_d;
    sum_d.raw_over  = (byte_idx_d == CapV);
    sum_d.trim_hi   = sat8(PW'(trim_cnt_d));
    sum_d.trim_big  = (PW'(trim_cnt_d) > PW'(255));
    sum_d.bad_char  = bad_char_d;
    sum_d.prefix    = prefix_d;
    sum_d.fields    = fields_d;
    sum_d.typ       = typ_d;
    sum_d.act_start = act_start_d;
    sum_d.act_cnt   = act_cnt_d;
    sum_d.act_bad   = act_bad_d;
    sum_d.pay_start = pay_start_d;
    sum_d.pay_cnt   = pay_cnt_d;
  end

  // state registers, cleared after every last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q  <= '0;
      started_q   <= 1'b0;
      trim_cnt_q  <= '0;
      pend_ws_q   <= '0;
      pend_ctl_q  <= 1'b0;
      bad_char_q  <= 1'b0;
      fields_q    <= 2'd0;
      prefix_q    <= 3'd0;
      typ_q       <= cmdv_pkg::TYP_IDLE;
      act_start_q <= 8'd0;
      act_cnt_q   <= 8'd0;
      act_bad_q   <= 1'b0;
      pay_start_q <= 8'd0;
      pay_cnt_q   <= 8'd0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        byte_idx_q  <= '0;
        started_q   <= 1'b0;
        trim_cnt_q  <= '0;
        pend_ws_q   <= '0;
        pend_ctl_q  <= 1'b0;
        bad_char_q  <= 1'b0;
        fields_q    <= 2'd0;
        prefix_q    <= 3'd0;
        typ_q       <= cmdv_pkg::TYP_IDLE;
        act_start_q <= 8'd0;
        act_cnt_q   <= 8'd0;
        act_bad_q   <= 1'b0;
        pay_start_q <= 8'd0;
        pay_cnt_q   <= 8'd0;
      end else begin
        byte_idx_q  <= byte_idx_d;
        started_q   <= started_d;
        trim_cnt_q  <= trim_cnt_d;
        pend_ws_q   <= pend_ws_d;
        pend_ctl_q  <= pend_ctl_d;
        bad_char_q  <= bad_char_d;
        fields_q    <= fields_d;
        prefix_q    <= prefix_d;
        typ_q       <= typ_d;
        act_start_q <= act_start_d;
        act_cnt_q   <= act_cnt_d;
        act_bad_q   <= act_bad_d;
        pay_start_q <= pay_start_d;
        pay_cnt_q   <= pay_cnt_d;
      end
    end
  end

  // summary register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_adv && s1_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_adv && s1_last_q) begin
      s2_q <= sum_d;
    end
  end

  // error priority and result fields
  logic [2:0]  err;
  logic        too_long;
  logic        has_pay;
  logic [39:0] tdata_d;
  logic [2:0]  tuser_d;

  always_comb begin
    too_long = s2_q.raw_over || s2_q.trim_big || (s2_q.trim_hi > max_len_q);
    if (!s2_q.started) begin
      err = cmdv_pkg::ERR_EMPTY;
    end else if (too_long) begin
      err = cmdv_pkg::ERR_TOO_LONG;
    end else if (s2_q.bad_char) begin
      err = cmdv_pkg::ERR_BAD_CHAR;
    end else if (s2_q.prefix != cmdv_pkg::PFX_DONE) begin
      err = cmdv_pkg::ERR_BAD_FORMAT;
    end else if ((s2_q.fields == 2'd0) || (s2_q.act_cnt == 8'd0)) begin
      err = cmdv_pkg::ERR_NO_ACTION;
    end else if ((s2_q.typ != cmdv_pkg::TYP_GET) && (s2_q.typ != cmdv_pkg::TYP_SET)) begin
      err = cmdv_pkg::ERR_BAD_TYPE;
    end else if (s2_q.act_bad) begin
      err = cmdv_pkg::ERR_BAD_ACTION;
    end else begin
      err = cmdv_pkg::ERR_NONE;
    end

    has_pay = (err == cmdv_pkg::ERR_NONE) && (s2_q.fields == 2'd2);
    tdata_d = '0;
    tdata_d[2:0] = err;
    if (err == cmdv_pkg::ERR_NONE) begin
      tdata_d[10:3]  = s2_q.act_start;
      tdata_d[18:11] = s2_q.act_cnt;
    end
    if (has_pay) begin
      tdata_d[26:19] = s2_q.pay_start;
      tdata_d[34:27] = s2_q.pay_cnt;
    end
    tuser_d[0] = (err == cmdv_pkg::ERR_NONE);
    if (err != cmdv_pkg::ERR_NONE) begin
      tuser_d[2:1] = cmdv_pkg::KIND_NONE;
    end else if (s2_q.typ == cmdv_pkg::TYP_GET) begin
      tuser_d[2:1] = cmdv_pkg::KIND_GET;
    end else begin
      tuser_d[2:1] = cmdv_pkg::KIND_SET;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s2_v_q) begin
      m_axis_tdata <= tdata_d;
      m_axis_tuser <= tuser_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;

  // checks
  a_valid_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[2:0] == cmdv_pkg::ERR_NONE)))
    else $error("line_valid disagrees with error code");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[34:3] == 32'd0) && (m_axis_tuser[2:1] == cmdv_pkg::KIND_NONE))
    else $error("invalid line reports fields");

  a_summary_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !out_free) |=> (s2_v_q && $stable(s2_q)))
    else $error("line summary lost while result stalled");

  a_pending_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_ws_q != '0) |-> started_q)
    else $error("pending whitespace before content");

endmodule

`default_nettype wire

@@ sim/command_line_validator_test.sv @@
// ----------------------------------------------------------------------------
// command_line_validator_test
// Self-checking bench for the command line validator. Lines are streamed a
// byte per word through s_axis. A built-in line scanner predicts one result
// word per line, and each m_axis word is compared field by field against it.
// A short directed table comes first, then random lines in phases with
// different length limits and handshake pressure.
// ----------------------------------------------------------------------------

module command_line_validator_test;

  timeunit 1ns;
  timeprecision 1ps;

  import cmdv_pkg::*;

  localparam int LineMax     = LineMaxDefault;
  localparam int LineCap     = LineMaxDefault + 1;
  localparam int PhaseBytes  = 130;
  localparam int LongHold    = 300;
  localparam int QuietLimit  = 5000;
  localparam int Predicted   = -1;
  localparam logic [39:0] PrefixText = "CMND ";

  // one result word, unpacked
  typedef struct packed {
    logic       ok;
    logic [2:0] err;
    logic [1:0] kind;
    logic [7:0] act_off;
    logic [7:0] act_len;
    logic [7:0] pay_off;
    logic [7:0] pay_len;
  } verdict_t;

  // dut ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] char_byte
  logic        s_axis_tlast = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [2:0] error_code, [10:3] action_offset,
                                    // [18:11] action_length, [26:19] payload_offset,
                                    // [34:27] payload_length, [39:35] zero
  logic [2:0]  m_axis_tuser;        // [0] line_valid, [2:1] command_kind
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  // bench state
  verdict_t   verdicts[$];
  logic [7:0] line_buf[$];
  int         mismatches = 0;
  int         bytes_sent = 0;
  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  int         holds_asked = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  int         pinned_err = Predicted;

  // line scanner state
  int         len_limit;
  int         line_pos;
  bit         began;
  int         trim_cnt;
  int         ws_run;
  bit         ws_ctrl;
  bit         ctrl_seen;
  int         fields;
  logic [2:0] pfx_st;
  logic [2:0] typ_st;
  int         act_pos;
  int         act_cnt;
  bit         act_bad;
  int         pay_pos;
  int         pay_cnt;

  // directed lines: '#' stands for byte 0x00 and '$' for byte 0xff
  localparam int DirRows = 16;
  string dir_text [DirRows] = '{
    " ",
    "\t\015\012 \013\014",
    "CMND GET status",
    "  CMND SET mode.x-1_A   pay  load ~  \t ",
    "CMND GET a\tb",
    "CMND SET a#",
    "$",
    "cmnd GET a",
    "CMND GET ",
    "CMND SET  x",
    "CMND PUT x",
    "CMND GETS x",
    "CMND GET a/b",
    "CMND SET Z9.z0_- ",
    "CMND GET x y",
    "CMNDGET x"
  };
  int dir_err [DirRows] = '{
    ERR_EMPTY, ERR_EMPTY, Predicted, Predicted, ERR_BAD_CHAR, ERR_BAD_CHAR,
    ERR_BAD_CHAR, ERR_BAD_FORMAT, ERR_NO_ACTION, ERR_NO_ACTION, ERR_BAD_TYPE,
    ERR_BAD_TYPE, ERR_BAD_ACTION, Predicted, Predicted, ERR_BAD_FORMAT
  };

  command_line_validator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // line scanner
  // ---------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

  function automatic bit is_word_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "0") && (c <= "9")) || (c == ".") || (c == "_") || (c == "-");
  endfunction

  // GET / SET recognizer
  function automatic logic [2:0] next_type(input logic [2:0] s, input logic [7:0] c);
    case (s)
      TYP_IDLE: return (c == "G") ? TYP_G : ((c == "S") ? TYP_S : TYP_FAIL);
      TYP_G:    return (c == "E") ? TYP_GE : TYP_FAIL;
      TYP_S:    return (c == "E") ? TYP_SE : TYP_FAIL;
      TYP_GE:   return (c == "T") ? TYP_GET : TYP_FAIL;
      TYP_SE:   return (c == "T") ? TYP_SET : TYP_FAIL;
      default:  return TYP_FAIL;
    endcase
  endfunction

  task automatic clear_line_state();
    line_pos  = 0;
    began     = 1'b0;
    trim_cnt  = 0;
    ws_run    = 0;
    ws_ctrl   = 1'b0;
    ctrl_seen = 1'b0;
    fields    = 0;
    pfx_st    = '0;
    typ_st    = TYP_IDLE;
    act_pos   = 0;
    act_cnt   = 0;
    act_bad   = 1'b0;
    pay_pos   = 0;
    pay_cnt   = 0;
  endtask

  // one byte known to lie inside the trimmed line
  task automatic take_trimmed(input logic [7:0] c, input int pos);
    if (pfx_st < PFX_DONE) begin
      pfx_st = (c == PrefixText[8*(4-pfx_st) +: 8]) ? pfx_st + 3'd1 : PFX_FAIL;
    end else if (pfx_st == PFX_DONE) begin
      if (fields == 0) begin
        if (c == CH_SPACE) begin
          fields  = 1;
          act_pos = (pos + 1 > 255) ? 255 : pos + 1;
        end else begin
          typ_st = next_type(typ_st, c);
        end
      end else if (fields == 1) begin
        if (c == CH_SPACE) begin
          fields  = 2;
          pay_pos = (pos + 1 > 255) ? 255 : pos + 1;
        end else begin
          act_cnt = (act_cnt >= 255) ? 255 : act_cnt + 1;
          if (!is_word_char(c)) act_bad = 1'b1;
        end
      end else begin
        pay_cnt = (pay_cnt >= 255) ? 255 : pay_cnt + 1;
      end
    end
  endtask

  // advance the scanner by one raw byte; on the last byte, give the verdict
  task automatic scan_byte(input logic [7:0] c, input logic last,
                           output verdict_t v, output bit done);
    int pos;
    int k;
    int base;
    int j;
    logic [2:0] err;
    pos = line_pos;
    line_pos = (line_pos >= LineCap) ? LineCap : line_pos + 1;
    if (is_blank(c)) begin
      // hold whitespace after content until it proves to be interior
      if (began) begin
        ws_run = (ws_run >= LineCap) ? LineCap : ws_run + 1;
        if (c != CH_SPACE) ws_ctrl = 1'b1;
      end
    end else begin
      k = ws_run;
      base = (pos >= k) ? pos - k : 0;
      began = 1'b1;
      trim_cnt = (trim_cnt + k + 1 > LineCap) ? LineCap : trim_cnt + k + 1;
      if (ws_ctrl) begin
        ctrl_seen = 1'b1;
      end else begin
        for (j = 0; j < k; j++) take_trimmed(CH_SPACE, base + j);
      end
      ws_run  = 0;
      ws_ctrl = 1'b0;
      if ((c < CH_SPACE) || (c > CH_TILDE)) ctrl_seen = 1'b1;
      take_trimmed(c, pos);
    end
    v = '0;
    done = last;
    if (last) begin
      // first error in priority order
      if (!began)                                           err = ERR_EMPTY;
      else if ((trim_cnt > len_limit) || (line_pos > LineMax)) err = ERR_TOO_LONG;
      else if (ctrl_seen)                                   err = ERR_BAD_CHAR;
      else if (pfx_st != PFX_DONE)                          err = ERR_BAD_FORMAT;
      else if ((fields == 0) || (act_cnt == 0))             err = ERR_NO_ACTION;
      else if ((typ_st != TYP_GET) && (typ_st != TYP_SET))  err = ERR_BAD_TYPE;
      else if (act_bad)                                     err = ERR_BAD_ACTION;
      else                                                  err = ERR_NONE;
      v.err  = err;
      v.ok   = (err == ERR_NONE);
      v.kind = KIND_NONE;
      if (v.ok) begin
        v.kind    = (typ_st == TYP_GET) ? KIND_GET : KIND_SET;
        v.act_off = 8'(act_pos);
        v.act_len = 8'(act_cnt);
        if (fields == 2) begin
          v.pay_off = 8'(pay_pos);
          v.pay_len = 8'(pay_cnt);
        end
      end
      clear_line_state();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  task automatic offer_byte(input logic [7:0] c, input logic last);
    verdict_t v;
    bit done;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_byte(c, last, v, done);
    if (done) begin
      // directed rows may carry a hand-written error code
      if (pinned_err != Predicted) begin
        v      = '0;
        v.err  = 3'(pinned_err);
        v.kind = KIND_NONE;
      end
      verdicts.push_back(v);
    end
    bytes_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) offer_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  task automatic append_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 2) == 0) ? 8'(9 + $urandom_range(0, 4)) : CH_SPACE;
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 64);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    if (r == 62) return ".";
    if (r == 63) return "_";
    return "-";
  endfunction

  // compose one random line into line_buf; long_len > 0 forces a long line
  task automatic build_line(input int long_len, input int long_lead);
    int r;
    int n;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if ((long_len == 0) && (r < 3)) begin
      long_len  = $urandom_range(230, 300);
      long_lead = ($urandom_range(0, 3) == 0) ? long_len : $urandom_range(0, 20);
    end
    if (long_len > 0) begin
      // long line: leading whitespace, then, if room is left, a SET with a filled payload
      repeat (long_lead) line_buf.push_back(rand_blank());
      if (line_buf.size() < long_len) append_text("CMND SET a ");
      while (line_buf.size() < long_len) line_buf.push_back(8'($urandom_range(33, 126)));
    end else if (r < 12) begin
      // noise
      repeat ($urandom_range(1, 16)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 16) begin
      // whitespace only
      repeat ($urandom_range(1, 5)) line_buf.push_back(rand_blank());
    end else begin
      // command line, mostly well formed, with random content
      repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
      append_text("CMND ");
      r = $urandom_range(0, 19);
      if (r < 9) begin
        append_text("GET");
      end else if (r < 18) begin
        append_text("SET");
      end else begin
        repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(65, 90)));
      end
      line_buf.push_back(CH_SPACE);
      repeat ($urandom_range(1, 10)) begin
        line_buf.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(33, 126))
                                                        : rand_word_char());
      end
      if ($urandom_range(0, 9) < 6) begin
        line_buf.push_back(CH_SPACE);
        repeat ($urandom_range(1, 20)) begin
          line_buf.push_back(($urandom_range(0, 4) == 0) ? CH_SPACE
                                                         : 8'($urandom_range(33, 126)));
        end
      end
      repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
      // occasional damage: one corrupted byte or a cut line
      r = $urandom_range(0, 9);
      if (r == 0) begin
        line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (r == 1) begin
        n = $urandom_range(1, line_buf.size());
        while (line_buf.size() > n) void'(line_buf.pop_back());
      end
    end
  endtask

  task automatic random_lines();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      build_line(0, 0);
      send_line();
    end
  endtask

  // stop sending and wait for every outstanding result word
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    len_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    int k;
    logic [7:0] c;
    len_limit = MaxLenReset;
    clear_line_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset limit
    src_idle_pct = 25;
    snk_idle_pct = 50;
    for (i = 0; i < DirRows; i++) begin
      line_buf.delete();
      for (k = 0; k < dir_text[i].len(); k++) begin
        c = dir_text[i][k];
        if (c == "#") c = 8'h00;
        if (c == "$") c = 8'hff;
        line_buf.push_back(c);
      end
      pinned_err = dir_err[i];
      send_line();
    end
    pinned_err = Predicted;

    // widest limit with the raw length extremes
    write_limit(8'd255);
    build_line(LineMax, 1);
    send_line();
    build_line(LineMax + 1, 240);
    send_line();
    build_line(LineMax + 2, LineMax + 2);
    send_line();
    random_lines();

    write_limit(8'd1);
    random_lines();

    // swap idling; long receiver hold-off while lines keep coming
    src_idle_pct = 50;
    snk_idle_pct = 25;
    write_limit(MaxLenReset);
    holds_asked++;
    random_lines();

    write_limit(8'($urandom_range(12, 40)));
    random_lines();

    // full rate on both sides
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_limit(8'($urandom_range(2, 254)));
    random_lines();

    write_limit(8'd30);
    random_lines();

    drain_results();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  // receiver ready with random stalls and an occasional long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdicts.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, got tdata %h tuser %h",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = verdicts.pop_front();
        check_field("line_valid", want.ok, m_axis_tuser[0]);
        check_field("command_kind", want.kind, m_axis_tuser[2:1]);
        check_field("error_code", want.err, m_axis_tdata[2:0]);
        check_field("action_offset", want.act_off, m_axis_tdata[10:3]);
        check_field("action_length", want.act_len, m_axis_tdata[18:11]);
        check_field("payload_offset", want.pay_off, m_axis_tdata[26:19]);
        check_field("payload_length", want.pay_len, m_axis_tdata[34:27]);
        check_field("tdata pad", 0, m_axis_tdata[39:35]);
      end
    end
  end

  // end the run if no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t ns: no word moved for %0d cycles", $time, QuietLimit);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ command_line_validator.f @@
rtl/cmdv_pkg.sv
rtl/command_line_validator.sv
sim/command_line_validator_test.sv
